[hw/rtl/nrd_pkg.sv]
// Shared types for the non-restoring divider.
// Holds the per-round operation code and the stage control word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nrd_pkg;

	// Operation that the next round applies to the partial remainder.
	typedef enum logic {
		OP_SUB = 1'b0,
		OP_ADD = 1'b1
	} nrd_op_t;

	// Control word that travels with each word down the pipeline.
	typedef struct packed {
		logic    valid;
		nrd_op_t op;
	} nrd_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/nrd_ifs.sv]
// Valid/ready channel interfaces for the divider operand and result words.
// Standalone; payload widths follow the WIDTH parameter.
`timescale 1ns / 1ps
`default_nettype none

interface nrd_operand_if #(
	parameter int WIDTH = 16
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] dividend_in;
	logic [WIDTH-1:0] divisor_in;

	modport source (output valid, output dividend_in, output divisor_in, input ready);
	modport sink (input valid, input dividend_in, input divisor_in, output ready);
endinterface

interface nrd_result_if #(
	parameter int WIDTH = 16
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] quotient_out;
	logic [WIDTH-1:0] remainder_out;

	modport source (output valid, output quotient_out, output remainder_out, input ready);
	modport sink (input valid, input quotient_out, input remainder_out, output ready);
endinterface

`default_nettype wire

[hw/rtl/nrd_round.sv]
// One registered round of non-restoring division.
// Depends on nrd_pkg for the operation code and stage control word.
`timescale 1ns / 1ps
`default_nettype none

module nrd_round #(
	parameter int WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nrd_pkg::nrd_ctl_t up_ctl,
	output logic                   up_ready,
	input  wire logic [WIDTH:0]    up_a,
	input  wire logic [WIDTH-1:0]  up_q,
	input  wire logic [WIDTH-1:0]  up_d,
	output nrd_pkg::nrd_ctl_t      dn_ctl,
	input  wire logic              dn_ready,
	output logic [WIDTH:0]         dn_a,
	output logic [WIDTH-1:0]       dn_q,
	output logic [WIDTH-1:0]       dn_d
);
	import nrd_pkg::*;

	nrd_ctl_t         ctl_s1;
	logic [WIDTH:0]   a_s1;
	logic [WIDTH-1:0] q_s1;
	logic [WIDTH-1:0] d_s1;

	logic [WIDTH:0]   a_shift;
	logic [WIDTH:0]   a_next;
	logic [WIDTH-1:0] q_next;

	// The top quotient bit moves into the partial remainder, then the divisor
	// is added or subtracted as chosen by the previous round's sign.
	always_comb begin
		a_shift = {up_a[WIDTH-1:0], up_q[WIDTH-1]};
		if (up_ctl.op == OP_ADD) begin
			a_next = a_shift + {1'b0, up_d};
		end else begin
			a_next = a_shift - {1'b0, up_d};
		end
		q_next = {up_q[WIDTH-2:0], ~a_next[WIDTH]};
	end

	assign up_ready = !ctl_s1.valid || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (up_ready) begin
			ctl_s1.valid <= up_ctl.valid;
			ctl_s1.op    <= a_next[WIDTH] ? OP_ADD : OP_SUB;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_ctl.valid) begin
			a_s1 <= a_next;
			q_s1 <= q_next;
			d_s1 <= up_d;
		end
	end

	assign dn_ctl = ctl_s1;
	assign dn_a   = a_s1;
	assign dn_q   = q_s1;
	assign dn_d   = d_s1;

endmodule

`default_nettype wire

[hw/rtl/non_restoring_divider_unit.sv]
// Top level of the pipelined unsigned non-restoring divider.
// Depends on nrd_pkg, nrd_operand_if, nrd_result_if and nrd_round.
//
// The unit takes one dividend/divisor word per cycle and returns one
// quotient/remainder word per cycle while the result side is ready. A word
// passes WIDTH + 1 register stages: one per quotient bit, the first of which
// captures it at the accepting edge, and one output stage that applies the
// final remainder correction. Each stage holds its word while the next one is
// stalled, so back-pressure on the result side never drops or repeats a word,
// and bubbles are filled as the pipeline advances. A zero divisor raises no
// flag: the quotient comes back all ones and the remainder equals the dividend.
`timescale 1ns / 1ps
`default_nettype none

module non_restoring_divider_unit #(
	parameter int WIDTH = 16
) (
	input wire logic   clk,
	input wire logic   arst_n,
	nrd_operand_if.sink  operands,
	nrd_result_if.source results
);
	import nrd_pkg::*;

	nrd_ctl_t         ctl_w   [0:WIDTH];
	logic             ready_w [0:WIDTH];
	logic [WIDTH:0]   a_w     [0:WIDTH];
	logic [WIDTH-1:0] q_w     [0:WIDTH];
	logic [WIDTH-1:0] d_w     [0:WIDTH];

	logic             valid_q;
	logic [WIDTH-1:0] quotient_q;
	logic [WIDTH-1:0] remainder_q;
	logic             out_ready;

	// The partial remainder starts at zero, so the first round subtracts.
	assign ctl_w[0].valid = operands.valid;
	assign ctl_w[0].op    = OP_SUB;
	assign a_w[0]         = '0;
	assign q_w[0]         = operands.dividend_in;
	assign d_w[0]         = operands.divisor_in;
	assign operands.ready = ready_w[0];

	for (genvar k = 0; k < WIDTH; k++) begin : g_round
		nrd_round #(
			.WIDTH(WIDTH)
		) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_ctl   (ctl_w[k]),
			.up_ready (ready_w[k]),
			.up_a     (a_w[k]),
			.up_q     (q_w[k]),
			.up_d     (d_w[k]),
			.dn_ctl   (ctl_w[k+1]),
			.dn_ready (ready_w[k+1]),
			.dn_a     (a_w[k+1]),
			.dn_q     (q_w[k+1]),
			.dn_d     (d_w[k+1])
		);
	end

	assign out_ready      = !valid_q || results.ready;
	assign ready_w[WIDTH] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= ctl_w[WIDTH].valid;
		end
	end

	// A negative final remainder gets the divisor added back once; only the
	// low WIDTH bits of the sum are kept.
	always_ff @(posedge clk) begin
		if (out_ready && ctl_w[WIDTH].valid) begin
			quotient_q <= q_w[WIDTH];
			if (ctl_w[WIDTH].op == OP_ADD) begin
				remainder_q <= a_w[WIDTH][WIDTH-1:0] + d_w[WIDTH];
			end else begin
				remainder_q <= a_w[WIDTH][WIDTH-1:0];
			end
		end
	end

	assign results.valid         = valid_q;
	assign results.quotient_out  = quotient_q;
	assign results.remainder_out = remainder_q;

endmodule

`default_nettype wire

[test/nrd_result_checker.sv]
// Scoreboard for the non-restoring divider: watches the operand and result channels,
// predicts each quotient/remainder word and compares it in order.
// Depends on nrd_pkg for the per-round add/subtract code.
`timescale 1ns / 1ps

module nrd_result_checker #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             operand_valid,
	input  logic             operand_ready,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	input  logic             result_valid,
	input  logic             result_ready,
	input  logic [WIDTH-1:0] quotient,
	input  logic [WIDTH-1:0] remainder,
	output int               failures,
	output int               outstanding,
	output int               words_checked
);
	import nrd_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [WIDTH-1:0] dividend;
		logic [WIDTH-1:0] divisor;
		logic [WIDTH-1:0] quotient;
		logic [WIDTH-1:0] remainder;
	} division_t;

	division_t pending_divisions [$];

	// One add or subtract per quotient bit on a WIDTH+1 bit signed partial remainder,
	// then a single add-back when the remainder ends negative.
	function automatic division_t divide_word(logic [WIDTH-1:0] num, logic [WIDTH-1:0] den);
		logic [WIDTH:0]   partial;
		logic [WIDTH-1:0] quot;
		nrd_op_t          op;
		division_t        result;
		partial = '0;
		quot = num;
		for (int i = 0; i < WIDTH; i++) begin
			op = partial[WIDTH] ? OP_ADD : OP_SUB;
			partial = {partial[WIDTH-1:0], quot[WIDTH-1]};
			quot = {quot[WIDTH-2:0], 1'b0};
			if (op == OP_ADD) begin
				partial = partial + {1'b0, den};
			end else begin
				partial = partial - {1'b0, den};
			end
			quot[0] = ~partial[WIDTH];
		end
		if (partial[WIDTH]) begin
			partial = partial + {1'b0, den};
		end
		result.dividend = num;
		result.divisor = den;
		result.quotient = quot;
		result.remainder = partial[WIDTH-1:0];
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		division_t want;
		if (!arst_n) begin
			pending_divisions.delete();
			failures <= 0;
			outstanding <= 0;
			words_checked <= 0;
		end else begin
			if (operand_valid && operand_ready) begin
				pending_divisions.push_back(divide_word(dividend, divisor));
			end
			if (result_valid && result_ready) begin
				if (pending_divisions.size() == 0) begin
					if (failures < REPORT_LIMIT) begin
						$display("[%0t] unexpected result word: q=%h r=%h",
							$realtime, quotient, remainder);
					end
					failures <= failures + 1;
				end else begin
					want = pending_divisions.pop_front();
					words_checked <= words_checked + 1;
					if (want.quotient !== quotient || want.remainder !== remainder) begin
						if (failures < REPORT_LIMIT) begin
							$display("[%0t] mismatch for %h / %h:", $realtime,
								want.dividend, want.divisor);
							if (want.quotient !== quotient) begin
								$display("    quotient  expected %h, got %h",
									want.quotient, quotient);
							end
							if (want.remainder !== remainder) begin
								$display("    remainder expected %h, got %h",
									want.remainder, remainder);
							end
						end
						failures <= failures + 1;
					end
				end
			end
			outstanding <= pending_divisions.size();
		end
	end

endmodule

[test/non_restoring_divider_unit_test.sv]
// Top of the divider testbench: clock, reset, operand stimulus in bursts, result stalls,
// a no-progress watchdog and the verdict. Depends on nrd_pkg, nrd_ifs,
// non_restoring_divider_unit and nrd_result_checker.
`timescale 1ns / 1ps

module non_restoring_divider_unit_test;

	localparam int WIDTH         = 16;
	localparam int RANDOM_WORDS  = 1650;
	localparam int DIRECTED_WORDS = 22;
	localparam int HOLD_CYCLES   = 250;
	localparam int STALL_LIMIT   = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nrd_operand_if #(.WIDTH(WIDTH)) operands ();
	nrd_result_if  #(.WIDTH(WIDTH)) results ();

	int failures;
	int outstanding;
	int words_checked;
	int words_sent = 0;
	int zero_divisors = 0;
	int burst_left = 0;
	int idle_count = 0;

	logic [WIDTH-1:0] directed_dividend [DIRECTED_WORDS] = '{
		16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h1234, 16'hFFFF, 16'hFFFF, 16'h0000,
		16'h0001, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFE, 16'h8000, 16'hFFFF,
		16'hAAAA, 16'h5555, 16'h0064, 16'h7FFF, 16'hFFFF, 16'h0001};
	logic [WIDTH-1:0] directed_divisor [DIRECTED_WORDS] = '{
		16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF,
		16'h0001, 16'h0001, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0002,
		16'h5555, 16'hAAAA, 16'h0007, 16'h7FFF, 16'h00FF, 16'hFFFF};

	non_restoring_divider_unit #(.WIDTH(WIDTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands),
		.results  (results)
	);

	nrd_result_checker #(.WIDTH(WIDTH)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operands.valid),
		.operand_ready (operands.ready),
		.dividend      (operands.dividend_in),
		.divisor       (operands.divisor_in),
		.result_valid  (results.valid),
		.result_ready  (results.ready),
		.quotient      (results.quotient_out),
		.remainder     (results.remainder_out),
		.failures      (failures),
		.outstanding   (outstanding),
		.words_checked (words_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one word and returns once it has been taken. Between bursts the
	// operand valid drops for a random gap, sometimes none at all.
	task automatic offer_word(input logic [WIDTH-1:0] num, input logic [WIDTH-1:0] den);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				operands.valid <= 1'b0;
				operands.dividend_in <= WIDTH'($urandom);
				operands.divisor_in <= WIDTH'($urandom);
			end
		end
		burst_left--;
		@(negedge clk);
		operands.valid <= 1'b1;
		operands.dividend_in <= num;
		operands.divisor_in <= den;
		do begin
			@(posedge clk);
		end while (!operands.ready);
		words_sent++;
		if (den == '0) begin
			zero_divisors++;
		end
	endtask

	// Result side: segments of always-ready, light and heavy random stalls, plus one
	// long hold-off that lets the pipeline fill and push back on the operand side.
	initial begin
		int mode;
		int seg_len;
		int rx_cycles;
		bit held;
		rx_cycles = 0;
		held = 1'b0;
		results.ready = 1'b0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			seg_len = $urandom_range(10, 120);
			repeat (seg_len) begin
				@(negedge clk);
				case (mode)
					0: results.ready <= 1'b1;
					1: results.ready <= ($urandom_range(0, 3) != 0);
					2: results.ready <= ($urandom_range(0, 1) != 0);
					default: results.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
			rx_cycles += seg_len;
			if (!held && rx_cycles > 300) begin
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					results.ready <= 1'b0;
				end
				held = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((operands.valid && operands.ready) || (results.valid && results.ready)) begin
			idle_count <= 0;
		end else begin
			idle_count <= idle_count + 1;
		end
		if (idle_count >= STALL_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
				STALL_LIMIT, outstanding);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int kind;
		logic [WIDTH-1:0] num;
		logic [WIDTH-1:0] den;
		operands.valid = 1'b0;
		operands.dividend_in = '0;
		operands.divisor_in = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_WORDS; i++) begin
			offer_word(directed_dividend[i], directed_divisor[i]);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			kind = $urandom_range(0, 9);
			num = WIDTH'($urandom);
			den = WIDTH'($urandom);
			case (kind)
				4: den = WIDTH'($urandom_range(1, 15));
				5: begin
					// Mostly narrow divisors, now and then a zero one.
					if ($urandom_range(0, 3) == 0) begin
						den = '0;
					end else begin
						den = den >> $urandom_range(0, WIDTH - 1);
					end
				end
				6: begin
					if (den != '0) begin
						num = num % den;
					end
				end
				7: begin
					den = WIDTH'($urandom_range(1, 255));
					num = WIDTH'(den * $urandom_range(0, 16'hFFFF / den));
				end
				8: begin
					num = {{(WIDTH - 1){1'b0}}, 1'b1} << $urandom_range(0, WIDTH - 1);
					if ($urandom_range(0, 1) == 1) begin
						num = ~num;
					end
					den = {{(WIDTH - 1){1'b0}}, 1'b1} << $urandom_range(0, WIDTH - 1);
				end
				9: den = WIDTH'(num + $urandom_range(0, 6) - 3);
				default: ;
			endcase
			offer_word(num, den);
		end

		@(negedge clk);
		operands.valid <= 1'b0;

		wait (outstanding == 0);
		repeat (2 * WIDTH + 4) @(posedge clk);

		$display("Summary: %0d divisions sent, %0d with a zero divisor, %0d results compared,",
			words_sent, zero_divisors, words_checked);
		$display("         including a %0d-cycle result stall that backed up the operands.",
			HOLD_CYCLES);
		if (failures == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/nrd_pkg.sv
hw/rtl/nrd_ifs.sv
hw/rtl/nrd_round.sv
hw/rtl/non_restoring_divider_unit.sv
test/nrd_result_checker.sv
test/non_restoring_divider_unit_test.sv
